// ===== sv/nsr_pkg.sv =====
package nsr_pkg;

    localparam int WORD_W            = 32;
    localparam int ITER_W            = 10;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(32);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_OUT
    } t_state;

endpackage

// ===== sv/nsr_in_if.sv =====
interface nsr_in_if;
    import nsr_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] radicand;

    modport source (output valid, output radicand, input ready);
    modport sink   (input valid, input radicand, output ready);
endinterface

// ===== sv/nsr_out_if.sv =====
interface nsr_out_if;
    import nsr_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] root;

    modport source (output valid, output root, input ready);
    modport sink   (input valid, input root, output ready);
endinterface

// ===== sv/nsr_cfg_if.sv =====
interface nsr_cfg_if;
    import nsr_pkg::*;

    logic              valid;
    logic              ready;
    logic [ITER_W-1:0] iteration_count;

    modport source (output valid, output iteration_count, input ready);
    modport sink   (input valid, input iteration_count, output ready);
endinterface

// ===== sv/nsr_divider.sv =====
module nsr_divider #(
    parameter int FRACTION_BITS = nsr_pkg::FRACTION_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_start,
    input  logic [nsr_pkg::WORD_W+FRACTION_BITS-1:0]    i_dividend,
    input  logic [nsr_pkg::WORD_W-1:0]                  i_divisor,
    output logic                                        o_done,
    output logic [nsr_pkg::WORD_W-1:0]                  o_quotient
);
    import nsr_pkg::*;

    localparam int DVD_W = WORD_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_dsr;
    logic [DVD_W-1:0]  r_dvd;
    logic [DVD_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [WORD_W:0]   w_shift;
    logic [WORD_W:0]   w_diff;
    logic              w_fit;

    assign w_shift = {r_rem, r_dvd[DVD_W-1]};
    assign w_fit   = w_shift >= {1'b0, r_dsr};
    assign w_diff  = w_shift - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_dvd <= i_dividend;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[WORD_W-1:0] : w_shift[WORD_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[DVD_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = (r_quo[DVD_W-1:WORD_W] != '0) ? '1 : r_quo[WORD_W-1:0];

endmodule

// ===== sv/newton_square_root.sv =====
// Fixed-point square root by Newton-Raphson iteration on unsigned Q(32-F).F values
// (Q16.16 by default). The guess starts at 1.0 and each of iteration_count steps
// computes guess = (guess + (radicand << F) / guess) >> 1 with a truncating divide
// whose quotient saturates to all ones on overflow. Zero steps return 1.0; a guess
// that reaches 0 (a zero radicand halves it each step) ends the item with result 0.
// All steps share one restoring divider that retires one quotient bit per cycle.
// The reset iteration_count is 32. One item is in flight at a time; the result is
// held until transferred. iteration_count is written through the cfg channel, and
// the user must write it only while the block is idle; the block does not enforce it.
module newton_square_root #(
    parameter int FRACTION_BITS = nsr_pkg::FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nsr_in_if.sink      i_radicand,
    nsr_out_if.source   o_root,
    nsr_cfg_if.sink     i_cfg
);
    import nsr_pkg::*;

    localparam logic [WORD_W-1:0] GUESS_ONE = WORD_W'(1) << FRACTION_BITS;

    t_state            r_state;
    t_state            n_state;
    logic [ITER_W-1:0] r_iter;
    logic [ITER_W-1:0] r_step;
    logic [WORD_W-1:0] r_radicand;
    logic [WORD_W-1:0] r_guess;

    logic              w_in_xfer;
    logic              w_out_xfer;
    logic              w_div_start;
    logic              w_div_done;
    logic [WORD_W-1:0] w_quo;
    logic [WORD_W:0]   w_sum;
    logic              w_last;

    assign w_in_xfer  = i_radicand.valid && i_radicand.ready;
    assign w_out_xfer = o_root.valid && o_root.ready;
    assign w_sum      = {1'b0, r_guess} + {1'b0, w_quo};
    assign w_last     = ({1'b0, r_step} + (ITER_W+1)'(1)) == {1'b0, r_iter};

    nsr_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({r_radicand, {FRACTION_BITS{1'b0}}}),
        .i_divisor  (r_guess),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (r_iter == '0) ? S_OUT : S_START;
                end
            end
            S_START: begin
                n_state = (r_guess == '0) ? S_OUT : S_WAIT;
            end
            S_WAIT: begin
                if (w_div_done) begin
                    n_state = w_last ? S_OUT : S_START;
                end
            end
            S_OUT: begin
                if (w_out_xfer) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_radicand.ready = (r_state == S_IDLE);
        o_root.valid     = (r_state == S_OUT);
        w_div_start      = (r_state == S_START) && (r_guess != '0);
    end

    assign o_root.root = r_guess;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= ITER_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_iter <= i_cfg.iteration_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_radicand <= i_radicand.radicand;
            r_guess    <= GUESS_ONE;
            r_step     <= '0;
        end else if ((r_state == S_WAIT) && w_div_done) begin
            r_guess <= w_sum[WORD_W:1];
            r_step  <= r_step + ITER_W'(1);
        end
    end

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_WAIT))
        else $error("divider done outside wait state");

    a_in_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state != S_IDLE))
        else $error("input transfer did not start work");

    a_out_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer |=> (r_state == S_IDLE))
        else $error("output transfer did not return to idle");

    a_zero_iter_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (r_iter == '0)) |=> (o_root.valid && (o_root.root == GUESS_ONE)))
        else $error("zero-step result is not one");

endmodule
